// ----- rtl/pcps_pkg.sv -----
// Package for the PERT critical path schedule unit.
// Holds the shared types, codes and constants; it depends on nothing else.
package pcps_pkg;

  localparam int MAX_TASKS_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 2;

  localparam int SUM_W  = 15;
  localparam int DUR_W  = 13;
  localparam int TIME_W = 21;
  localparam int LVL_W  = 7;
  localparam int TID_W  = 6;
  localparam int EDGE_W = 12;

  // floor(s / 6) == (s * RECIP_SIX) >> RECIP_SHIFT for every 15-bit s.
  localparam logic [15:0] RECIP_SIX   = 16'd43691;
  localparam int          RECIP_SHIFT = 18;

  typedef enum logic [1:0] {
    KIND_TASK = 2'd0,
    KIND_EDGE = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_MUL,
    ST_LD_WR,
    ST_F_INIT,
    ST_E_RD,
    ST_E_AD,
    ST_E_UP,
    ST_P_AD,
    ST_P_AC,
    ST_B_AD,
    ST_B_WR,
    ST_O_AD,
    ST_O_WR
  } state_t;

  typedef struct packed {
    logic task_cap;
    logic task_wr;
    logic edge_wr;
    logic run_start;
    logic counts_clr;
    logic clr_idx;
    logic inc_idx;
    logic clr_edge_idx;
    logic inc_edge_idx;
    logic addr_idx;
    logic init_fwd_wr;
    logic init_bwd_wr;
    logic pass_clr;
    logic fwd_up;
    logic bwd_up;
    logic pf_acc;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic room;
    logic n_zero;
    logic idx_last;
    logic edge_end;
    logic changed;
    logic cyc;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/pcps_ctrl.sv -----
// Controller of the PERT critical path schedule unit.
// Sequences loads, the forward and backward relaxation passes and the result
// sweep; it uses pcps_pkg.
module pcps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_kind,
  input  pcps_pkg::dp_status_t status,
  output pcps_pkg::dp_cmd_t    cmd
);
  import pcps_pkg::*;

  state_t state_r, state_nxt;
  logic   bwd_r, bwd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bwd_r   <= bwd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bwd_nxt   = bwd_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (kind_t'(in_kind))
            KIND_TASK: begin
              if (status.room) begin
                cmd.task_cap = 1'b1;
                state_nxt    = ST_LD_MUL;
              end
            end
            KIND_EDGE: begin
              cmd.edge_wr = 1'b1;
            end
            KIND_RUN: begin
              if (status.n_zero) begin
                cmd.counts_clr = 1'b1;
              end else begin
                cmd.run_start = 1'b1;
                cmd.clr_idx   = 1'b1;
                state_nxt     = ST_F_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD_MUL: begin
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd.task_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_F_INIT: begin
        cmd.init_fwd_wr = 1'b1;
        if (status.idx_last) begin
          cmd.clr_edge_idx = 1'b1;
          cmd.pass_clr     = 1'b1;
          bwd_nxt          = 1'b0;
          state_nxt        = ST_E_RD;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      ST_E_RD: begin
        if (status.edge_end) begin
          if (status.cyc) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = ST_O_AD;
          end else if (status.changed) begin
            cmd.pass_clr     = 1'b1;
            cmd.clr_edge_idx = 1'b1;
          end else if (!bwd_r) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = ST_P_AD;
          end else begin
            cmd.clr_idx = 1'b1;
            state_nxt   = ST_O_AD;
          end
        end else begin
          state_nxt = ST_E_AD;
        end
      end
      ST_E_AD: begin
        state_nxt = ST_E_UP;
      end
      ST_E_UP: begin
        cmd.fwd_up       = !bwd_r;
        cmd.bwd_up       = bwd_r;
        cmd.inc_edge_idx = 1'b1;
        state_nxt        = ST_E_RD;
      end
      ST_P_AD: begin
        cmd.addr_idx = 1'b1;
        state_nxt    = ST_P_AC;
      end
      ST_P_AC: begin
        cmd.addr_idx = 1'b1;
        cmd.pf_acc   = 1'b1;
        if (status.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = ST_B_AD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = ST_P_AD;
        end
      end
      ST_B_AD: begin
        cmd.addr_idx = 1'b1;
        state_nxt    = ST_B_WR;
      end
      ST_B_WR: begin
        cmd.addr_idx    = 1'b1;
        cmd.init_bwd_wr = 1'b1;
        if (status.idx_last) begin
          cmd.clr_edge_idx = 1'b1;
          cmd.pass_clr     = 1'b1;
          bwd_nxt          = 1'b1;
          state_nxt        = ST_E_RD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = ST_B_AD;
        end
      end
      ST_O_AD: begin
        cmd.addr_idx = 1'b1;
        state_nxt    = ST_O_WR;
      end
      ST_O_WR: begin
        cmd.addr_idx = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.idx_last) begin
            cmd.counts_clr = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = ST_O_AD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pcps_datapath.sv -----
// Datapath of the PERT critical path schedule unit: task and edge stores,
// per-task time memories, relaxation arithmetic and the result register.
// It uses pcps_pkg and is driven by pcps_ctrl.
module pcps_datapath #(
  parameter int MAX_TASKS = pcps_pkg::MAX_TASKS_DEF,
  parameter int MAX_EDGES = pcps_pkg::MAX_EDGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [pcps_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  pcps_pkg::dp_cmd_t                    cmd,
  output pcps_pkg::dp_status_t                 status,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pcps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [pcps_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                 out_tlast
);
  import pcps_pkg::*;

  localparam int TAW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TCW = $clog2(MAX_TASKS + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);

  function automatic logic [TIME_W-1:0] late_start(input logic [TIME_W-1:0] lf,
                                                   input logic [DUR_W-1:0]  d,
                                                   input logic              rnz);
    logic signed [TIME_W:0] diff;
    diff = $signed({lf[TIME_W-1], lf}) - $signed({{(TIME_W+1-DUR_W){1'b0}}, d});
    late_start = TIME_W'(diff - (TIME_W+1)'(rnz && (diff > 0)));
  endfunction

  logic [DUR_W:0]       dur_mem [MAX_TASKS];
  logic [TIME_W-1:0]    es_mem  [MAX_TASKS];
  logic [LVL_W-1:0]     lvl_mem [MAX_TASKS];
  logic [TIME_W-1:0]    ls_mem  [MAX_TASKS];
  logic [TIME_W-1:0]    lf_mem  [MAX_TASKS];
  logic [EDGE_W-1:0]    edge_mem [MAX_EDGES];

  logic [TCW-1:0]       task_cnt_r;
  logic [ECW-1:0]       edge_cnt_r;
  logic [SUM_W-1:0]     s_r;
  logic [TAW-1:0]       ld_addr_r;
  logic [SUM_W+15:0]    prod_r;
  logic [TAW-1:0]       idx_r;
  logic [ECW-1:0]       eidx_r;
  logic [EDGE_W-1:0]    edge_q_r;
  logic [TIME_W-1:0]    es_qa_r, es_qb_r, ls_qa_r, ls_qb_r, lf_qa_r;
  logic [LVL_W-1:0]     lvl_qa_r, lvl_qb_r;
  logic [DUR_W:0]       dur_qa_r;
  logic [TIME_W-1:0]    pf_r;
  logic                 changed_r;
  logic                 cyc_r;
  logic                 out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;
  logic                 out_tlast_r;

  logic [6:0]           src, dst;
  logic                 edge_in_ok;
  logic [SUM_W-1:0]     s_nxt;
  logic [DUR_W-1:0]     ld_dur;
  logic [SUM_W:0]       six_dur;
  logic                 ld_rnz;
  logic [TID_W-1:0]     edge_a, edge_b;
  logic                 edge_ok;
  logic [TAW-1:0]       addr_a, addr_b;
  logic [DUR_W-1:0]     dur_a;
  logic [TIME_W-1:0]    ef_a, es_new;
  logic [LVL_W-1:0]     lvl_inc, lvl_new;
  logic                 fwd_chg, fwd_wr, bwd_wr, bwd_less;
  logic                 out_free;
  logic [TIME_W-1:0]    o_es, o_ef, o_ls, o_lf;
  logic [TIME_W:0]      o_fl;
  logic                 o_crit;

  assign src = in_tdata[42:36];
  assign dst = in_tdata[49:43];
  assign edge_in_ok = (src != 7'd0) && (src <= 7'(MAX_TASKS)) &&
                      (dst != 7'd0) && (dst <= 7'(MAX_TASKS)) &&
                      (edge_cnt_r < ECW'(MAX_EDGES));
  assign s_nxt = {3'b000, in_tdata[11:0]} + {1'b0, in_tdata[23:12], 2'b00} +
                 {3'b000, in_tdata[35:24]};

  assign ld_dur  = prod_r[RECIP_SHIFT+DUR_W-1:RECIP_SHIFT];
  assign six_dur = {2'b00, ld_dur, 1'b0} + {1'b0, ld_dur, 2'b00};
  assign ld_rnz  = (six_dur != {1'b0, s_r});

  assign edge_a  = edge_q_r[EDGE_W-1:TID_W];
  assign edge_b  = edge_q_r[TID_W-1:0];
  assign edge_ok = (7'(edge_a) < 7'(task_cnt_r)) && (7'(edge_b) < 7'(task_cnt_r));
  assign addr_a  = cmd.addr_idx ? idx_r : edge_a[TAW-1:0];
  assign addr_b  = edge_b[TAW-1:0];

  assign dur_a    = dur_qa_r[DUR_W-1:0];
  assign ef_a     = es_qa_r + TIME_W'(dur_a);
  assign lvl_inc  = lvl_qa_r + 7'd1;
  assign es_new   = (ef_a > es_qb_r) ? ef_a : es_qb_r;
  assign lvl_new  = (lvl_inc > lvl_qb_r) ? lvl_inc : lvl_qb_r;
  assign fwd_chg  = (ef_a > es_qb_r) || (lvl_inc > lvl_qb_r);
  assign fwd_wr   = cmd.fwd_up && edge_ok && fwd_chg;
  assign bwd_less = $signed(ls_qb_r) < $signed(lf_qa_r);
  assign bwd_wr   = cmd.bwd_up && edge_ok && bwd_less;

  assign out_free = !out_tvalid_r || out_tready;

  assign o_es   = cyc_r ? '0 : es_qa_r;
  assign o_ef   = cyc_r ? '0 : ef_a;
  assign o_ls   = cyc_r ? '0 : ls_qa_r;
  assign o_lf   = cyc_r ? '0 : lf_qa_r;
  assign o_fl   = {o_ls[TIME_W-1], o_ls} - {1'b0, o_es};
  assign o_crit = !cyc_r && (o_fl == '0);

  always_ff @(posedge clk) begin
    if (cmd.task_wr) begin
      dur_mem[ld_addr_r] <= {ld_rnz, ld_dur};
    end
    if (cmd.edge_wr && edge_in_ok) begin
      edge_mem[edge_cnt_r[EAW-1:0]] <= {6'(src - 7'd1), 6'(dst - 7'd1)};
    end
    if (cmd.init_fwd_wr) begin
      es_mem[idx_r]  <= '0;
      lvl_mem[idx_r] <= '0;
    end else if (fwd_wr) begin
      es_mem[addr_b]  <= es_new;
      lvl_mem[addr_b] <= lvl_new;
    end
    if (cmd.init_bwd_wr) begin
      lf_mem[idx_r] <= pf_r;
      ls_mem[idx_r] <= late_start(pf_r, dur_a, dur_qa_r[DUR_W]);
    end else if (bwd_wr) begin
      lf_mem[addr_a] <= ls_qb_r;
      ls_mem[addr_a] <= late_start(ls_qb_r, dur_a, dur_qa_r[DUR_W]);
    end
    edge_q_r <= edge_mem[eidx_r[EAW-1:0]];
    dur_qa_r <= dur_mem[addr_a];
    es_qa_r  <= es_mem[addr_a];
    es_qb_r  <= es_mem[addr_b];
    lvl_qa_r <= lvl_mem[addr_a];
    lvl_qb_r <= lvl_mem[addr_b];
    ls_qa_r  <= ls_mem[addr_a];
    ls_qb_r  <= ls_mem[addr_b];
    lf_qa_r  <= lf_mem[addr_a];
  end

  always_ff @(posedge clk) begin
    prod_r <= {16'd0, s_r} * {15'd0, RECIP_SIX};
    if (cmd.task_cap) begin
      s_r       <= s_nxt;
      ld_addr_r <= task_cnt_r[TAW-1:0];
    end
    if (cmd.run_start) begin
      pf_r <= '0;
    end else if (cmd.pf_acc && (ef_a > pf_r)) begin
      pf_r <= ef_a;
    end
    if (cmd.out_load) begin
      out_tdata_r <= {7'd0, o_fl, o_lf, o_ls, o_ef, o_es, 7'(idx_r) + 7'd1};
      out_tuser_r <= {cyc_r, o_crit};
      out_tlast_r <= status.idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_cnt_r   <= '0;
      edge_cnt_r   <= '0;
      idx_r        <= '0;
      eidx_r       <= '0;
      changed_r    <= 1'b0;
      cyc_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.counts_clr) begin
        task_cnt_r <= '0;
        edge_cnt_r <= '0;
      end else begin
        if (cmd.task_cap) begin
          task_cnt_r <= task_cnt_r + TCW'(1);
        end
        if (cmd.edge_wr && edge_in_ok) begin
          edge_cnt_r <= edge_cnt_r + ECW'(1);
        end
      end
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + TAW'(1);
      end
      if (cmd.clr_edge_idx) begin
        eidx_r <= '0;
      end else if (cmd.inc_edge_idx) begin
        eidx_r <= eidx_r + ECW'(1);
      end
      if (cmd.pass_clr) begin
        changed_r <= 1'b0;
      end else if (fwd_wr || bwd_wr) begin
        changed_r <= 1'b1;
      end
      if (cmd.run_start) begin
        cyc_r <= 1'b0;
      end else if (cmd.fwd_up && edge_ok && (lvl_inc >= 7'(task_cnt_r))) begin
        cyc_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign status.room     = task_cnt_r < TCW'(MAX_TASKS);
  assign status.n_zero   = task_cnt_r == '0;
  assign status.idx_last = (TCW'(idx_r) + TCW'(1)) == task_cnt_r;
  assign status.edge_end = eidx_r == edge_cnt_r;
  assign status.changed  = changed_r;
  assign status.cyc      = cyc_r;
  assign status.out_free = out_free;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- rtl/pert_critical_path_schedule_unit.sv -----
// PERT critical path schedule unit. A task load is captured in idle and then
// passes the multiply and write states; an edge load is written from idle. A
// run first clears the early times of all n tasks, then repeats passes over
// the edge store, each edge read, addressed and updated in turn, until a pass
// changes nothing; the forward pass repeats at most the longest path, counted
// in edges, plus one times, and a cycle in the graph ends it after at most n
// passes. A project finish sweep and a late time set-up each walk the tasks, a
// backward pass set repeats like the forward one, and results leave in load
// order, one task at a time through an address and a write state, while the
// output is taken. The single shared edge memory read port and the task
// memories' registered reads set these steps, and the run clears both stores.
// Depends on pcps_pkg, pcps_ctrl and pcps_datapath.
module pert_critical_path_schedule_unit #(
  parameter int MAX_TASKS = pcps_pkg::MAX_TASKS_DEF,
  parameter int MAX_EDGES = pcps_pkg::MAX_EDGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // optimistic_time, likely_time, pessimistic_time, edge_source, edge_target
  input  logic [pcps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [pcps_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // task_number, early_start, early_finish, late_start, late_finish, total_float
  output logic [pcps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // critical, cycle_error
  output logic [pcps_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                             out_tlast
);
  import pcps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  pcps_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending transfer");

  a_cycle_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tuser[0] == 1'b0 && out_tdata[112:7] == '0))
    else $error("cycle result carries non-zero times");

  a_crit_float: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[112:91] == '0))
    else $error("critical task with non-zero float");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.task_cap || cmd.edge_wr) |=> !cmd.out_load)
    else $error("load overlapped with result output");

endmodule

// ----- dv/testbench.sv -----
// Testbench for pert_critical_path_schedule_unit: loads tasks and edges, runs schedules,
// and checks every schedule row against a predictor of the critical path method.
// Depends on pcps_pkg and the unit itself.
`timescale 1ns / 100ps

module testbench;
  import pcps_pkg::*;

  localparam int WATCHDOG_LIMIT = 500000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic [6:0]  task_no;
    logic [20:0] es;
    logic [20:0] ef;
    logic [20:0] ls;
    logic [20:0] lf;
    logic [21:0] fl;
    logic        crit;
    logic        cyc;
    logic        last;
  } sched_row_t;

  class cpm_schedule;
    int unsigned wsum[64];
    logic [11:0] edge_mem[256];
    longint      es_mem[64];
    longint      ls_mem[64];
    longint      lf_mem[64];
    int          n_tasks;
    int          n_edges;
    sched_row_t  expected_rows[$];
    int          errors;
    int          rows_seen;
    int          runs;
    int          cyclic_runs;

    function void take_item(kind_t k, logic [55:0] d);
      int a;
      int b;
      if (k == KIND_TASK && n_tasks < 64) begin
        wsum[n_tasks] = d[11:0] + 4 * d[23:12] + d[35:24];
        n_tasks++;
      end else if (k == KIND_EDGE) begin
        a = int'(d[42:36]);
        b = int'(d[49:43]);
        if (a >= 1 && a <= 64 && b >= 1 && b <= 64 && n_edges < 256) begin
          edge_mem[n_edges] = {6'(a - 1), 6'(b - 1)};
          n_edges++;
        end
      end else if (k == KIND_RUN) begin
        schedule();
      end
    endfunction

    function void schedule();
      int         order[64];
      int         indeg[64];
      int         head;
      int         tail;
      int         t;
      int         a;
      int         b;
      int         n;
      bit         cyc;
      longint     pf;
      longint     es;
      longint     lf;
      sched_row_t r;
      n = n_tasks;
      head = 0;
      tail = 0;
      for (int i = 0; i < 64; i++) indeg[i] = 0;
      for (int e = 0; e < n_edges; e++) begin
        a = edge_mem[e][11:6];
        b = edge_mem[e][5:0];
        if (a < n && b < n) indeg[b]++;
      end
      for (int i = 0; i < n; i++) if (indeg[i] == 0) order[tail++] = i;
      while (head < tail) begin
        t = order[head++];
        for (int e = 0; e < n_edges; e++) begin
          a = edge_mem[e][11:6];
          b = edge_mem[e][5:0];
          if (a == t && b < n) begin
            indeg[b]--;
            if (indeg[b] == 0) order[tail++] = b;
          end
        end
      end
      cyc = tail < n;
      pf = 0;
      if (!cyc) begin
        for (int k = 0; k < n; k++) begin
          t = order[k];
          es = 0;
          for (int e = 0; e < n_edges; e++) begin
            a = edge_mem[e][11:6];
            if (edge_mem[e][5:0] == t && a < n && es_mem[a] + wsum[a] / 6 > es)
              es = es_mem[a] + wsum[a] / 6;
          end
          es_mem[t] = es;
          if (es + wsum[t] / 6 > pf) pf = es + wsum[t] / 6;
        end
        for (int k = n - 1; k >= 0; k--) begin
          t = order[k];
          lf = pf;
          for (int e = 0; e < n_edges; e++) begin
            b = edge_mem[e][5:0];
            if (edge_mem[e][11:6] == t && b < n && ls_mem[b] < lf) lf = ls_mem[b];
          end
          lf_mem[t] = lf;
          ls_mem[t] = (6 * lf - longint'(wsum[t])) / 6;
        end
      end
      for (int i = 0; i < n; i++) begin
        r.task_no = 7'(i + 1);
        r.es = cyc ? '0 : 21'(es_mem[i]);
        r.ef = cyc ? '0 : 21'(es_mem[i] + wsum[i] / 6);
        r.ls = cyc ? '0 : 21'(ls_mem[i]);
        r.lf = cyc ? '0 : 21'(lf_mem[i]);
        r.fl = cyc ? '0 : 22'(ls_mem[i] - es_mem[i]);
        r.crit = !cyc && (ls_mem[i] == es_mem[i]);
        r.cyc = cyc;
        r.last = (i + 1 == n);
        expected_rows.insert(expected_rows.size(), r);
      end
      if (n > 0) runs++;
      if (n > 0 && cyc) cyclic_runs++;
      n_tasks = 0;
      n_edges = 0;
    endfunction

    function void compare(string name, logic [21:0] exp_v, logic [21:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_row(logic [119:0] d, logic [1:0] u, logic l);
      sched_row_t r;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %0h", $time, d);
        errors++;
        return;
      end
      r = expected_rows.pop_front();
      rows_seen++;
      compare("task_number", r.task_no, d[6:0]);
      compare("early_start", r.es, d[27:7]);
      compare("early_finish", r.ef, d[48:28]);
      compare("late_start", r.ls, d[69:49]);
      compare("late_finish", r.lf, d[90:70]);
      compare("total_float", r.fl, d[112:91]);
      compare("critical", r.crit, u[0]);
      compare("cycle_error", r.cyc, u[1]);
      compare("last", r.last, l);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  cpm_schedule sched = new();
  bit          no_idle = 1'b0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;

  pert_critical_path_schedule_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      out_tready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      holds_done = hold_reqs;
    end
    out_tready = no_idle || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sched.check_row(out_tdata, out_tuser, out_tlast);
    if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d rows outstanding", $time,
                 sched.expected_rows.size());
        $display("[pert_critical_path_schedule_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send(kind_t k, logic [55:0] d);
    while (!no_idle && $urandom_range(0, 99) < 29) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = d;
    in_tuser = k;
    do @(posedge clk); while (!in_tready);
    sched.take_item(k, d);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_task(int o, int m, int p);
    send(KIND_TASK, {6'd0, 14'($urandom), 12'(p), 12'(m), 12'(o)});
  endtask

  task automatic send_edge(int a, int b);
    send(KIND_EDGE, {6'd0, 7'(b), 7'(a), 36'({$urandom, $urandom})});
  endtask

  task automatic send_run();
    send(KIND_RUN, 56'({$urandom, $urandom}));
  endtask

  task automatic drain();
    while (sched.expected_rows.size() != 0) @(negedge clk);
  endtask

  task automatic random_job(int n, int m);
    int a;
    int r;
    for (int i = 0; i < n; i++)
      send_task($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
    for (int i = 0; i < m; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85 && n >= 2) begin
        a = $urandom_range(1, n - 1);
        send_edge(a, $urandom_range(a + 1, n));
      end else if (r < 93) begin
        send_edge($urandom_range(0, 127), $urandom_range(0, 127));
      end else if (r < 97) begin
        send_edge($urandom_range(1, n), $urandom_range(1, n));
      end else begin
        send(KIND_NONE, 56'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    int job;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_run();
    send_task(0, 0, 0);
    send_task(4095, 4095, 4095);
    send_task(1, 2, 3);
    send_task(4095, 0, 4095);
    send_edge(1, 2);
    send_edge(1, 2);
    send_edge(2, 4);
    send_edge(3, 4);
    send_edge(0, 3);
    send_edge(65, 1);
    send_edge(127, 127);
    send_edge(6, 1);
    send(KIND_NONE, 56'hFF_FFFF_FFFF_FFFF);
    send_run();
    send_task(10, 20, 30);
    send_task(5, 5, 5);
    send_edge(1, 2);
    send_edge(2, 1);
    send_run();
    send_task(7, 8, 9);
    send_edge(1, 1);
    send_run();

    job = 0;
    while (items_sent < 125) begin
      no_idle = (job >= 1 && job <= 2);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
      random_job(n, $urandom_range(0, 2 * n));
      if (job % 4 == 0) drain();
      if (job == 1) hold_reqs++;
      send_run();
      if (job == 1) begin
        for (int i = 0; i < 66; i++) send_task($urandom_range(0, 4095), 4095, $urandom);
        for (int i = 1; i < 64; i += 7) send_edge(i, i + 7);
        send_edge(64, 64);
        send_run();
      end
      job++;
    end
    no_idle = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d transfers in, %0d schedule runs (%0d cyclic), %0d rows checked.",
             items_sent, sched.runs, sched.cyclic_runs, sched.rows_seen);
    if (sched.errors == 0 && sched.expected_rows.size() == 0) begin
      $display("[pert_critical_path_schedule_unit] OK");
    end else begin
      $display("[pert_critical_path_schedule_unit] ERROR");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/pcps_pkg.sv
rtl/pcps_ctrl.sv
rtl/pcps_datapath.sv
rtl/pert_critical_path_schedule_unit.sv
dv/testbench.sv
